### hdl/chroma_420_downsampler_macros.svh
// ----------------------------------------------------------------------------
// chroma_420_downsampler_macros
// Assertion macros shared by the chroma 4:2:0 downsampler RTL.
// ----------------------------------------------------------------------------
`ifndef CHROMA_420_DOWNSAMPLER_MACROS_SVH
`define CHROMA_420_DOWNSAMPLER_MACROS_SVH

// same-cycle implication, disabled during reset
`define CHR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("chroma_420_downsampler: assertion failed");

// next-cycle implication, disabled during reset
`define CHR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("chroma_420_downsampler: assertion failed");

`endif

### hdl/chr420_pkg.sv
// ----------------------------------------------------------------------------
// chr420_pkg
// Types and constants of the chroma 4:2:0 downsampler.
// ----------------------------------------------------------------------------
package chr420_pkg;

    localparam int CFG_W          = 13;
    localparam int PIX_W          = 8;
    localparam int ROW_W          = 12;
    localparam int HEIGHT_LIMIT   = 4096;
    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int DEF_WIDTH      = 640;
    localparam int DEF_HEIGHT     = 480;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int APB_ADDR_W     = 3;
    localparam int APB_DATA_W     = 32;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] cr;
        logic [PIX_W-1:0] cb;
        logic [PIX_W-1:0] y;
    } t_pix;

    typedef struct packed {
        t_pix tl;
        t_pix tr;
        t_pix bl;
        t_pix br;
        logic frame_end;
    } t_blk;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QPTR_W:0]   count;
    } t_q_stat;

    typedef enum logic [1:0] {
        OP_DROP  = 2'd0,
        OP_STORE = 2'd1,
        OP_HOLD  = 2'd2,
        OP_DONE  = 2'd3
    } t_op;

endpackage

### hdl/chr420_ram.sv
// ----------------------------------------------------------------------------
// chr420_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module chr420_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/chr420_front.sv
// ----------------------------------------------------------------------------
// chr420_front
// Pixel intake: position counters, classification, line store and
// assembly of completed 2x2 blocks.
// ----------------------------------------------------------------------------
module chr420_front #(
    parameter int MAX_WIDTH = chr420_pkg::MAX_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [chr420_pkg::CFG_W-1:0] i_frame_width,
    input  logic [chr420_pkg::CFG_W-1:0] i_frame_height,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  chr420_pkg::t_pix             i_pix,
    output logic                         o_push,
    output chr420_pkg::t_blk             o_blk,
    input  logic                         i_q_full
);
    import chr420_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam logic [WW-1:0]    MaxW   = WW'(MAX_WIDTH);
    localparam logic [CFG_W-1:0] MaxH   = CFG_W'(HEIGHT_LIMIT);
    localparam logic [WW-1:0]    MinW   = WW'(2);
    localparam logic [CFG_W-1:0] MinH   = CFG_W'(2);

    logic [WW-1:0]    w_fw;
    logic [WW-1:0]    w_w;
    logic [WW-1:0]    w_w_even;
    logic [CFG_W-1:0] w_h;
    logic [CFG_W-1:0] w_h_even;
    logic [WW-1:0]    w_col_inc;
    logic [CFG_W-1:0] w_row_inc;
    logic             w_accept;
    logic             w_in_range;
    logic             w_fend;
    t_op              w_op;
    logic             w_s1_adv;
    t_pix             w_rdata;
    logic [3*PIX_W-1:0] w_rdata_raw;

    logic [CW-1:0]    r_col;
    logic [CW-1:0]    n_col;
    logic [ROW_W-1:0] r_row;
    logic [ROW_W-1:0] n_row;
    logic             r_s1_vld;
    logic             n_s1_vld;
    t_op              r_s1_op;
    t_pix             r_s1_pix;
    logic             r_s1_fend;
    t_pix             r_top_left;
    t_pix             r_held;

    assign w_fw = WW'(i_frame_width);
    assign w_w  = (w_fw < MinW) ? MinW : ((w_fw > MaxW) ? MaxW : w_fw);
    assign w_h  = (i_frame_height < MinH) ? MinH :
                  ((i_frame_height > MaxH) ? MaxH : i_frame_height);
    assign w_w_even = {w_w[WW-1:1], 1'b0};
    assign w_h_even = {w_h[CFG_W-1:1], 1'b0};

    assign w_in_range = (WW'(r_col) < w_w_even) && (CFG_W'(r_row) < w_h_even);
    assign w_fend     = (WW'(r_col) == (w_w_even - WW'(1))) &&
                        (CFG_W'(r_row) == (w_h_even - CFG_W'(1)));

    always_comb begin
        if (!w_in_range) begin
            w_op = OP_DROP;
        end else if (!r_row[0]) begin
            w_op = OP_STORE;
        end else if (!r_col[0]) begin
            w_op = OP_HOLD;
        end else begin
            w_op = OP_DONE;
        end
    end

    assign w_s1_adv = r_s1_vld && !((r_s1_op == OP_DONE) && i_q_full);
    assign o_ready  = !r_s1_vld || w_s1_adv;
    assign w_accept = i_valid && o_ready;

    assign w_col_inc = WW'(r_col) + WW'(1);
    assign w_row_inc = CFG_W'(r_row) + CFG_W'(1);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (w_accept) begin
            if (w_col_inc >= w_w) begin
                n_col = '0;
                n_row = (w_row_inc >= w_h) ? '0 : w_row_inc[ROW_W-1:0];
            end else begin
                n_col = w_col_inc[CW-1:0];
            end
        end
    end

    always_comb begin
        n_s1_vld = r_s1_vld;
        if (w_accept) begin
            n_s1_vld = 1'b1;
        end else if (w_s1_adv) begin
            n_s1_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_s1_vld <= 1'b0;
        end else begin
            r_col    <= n_col;
            r_row    <= n_row;
            r_s1_vld <= n_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_op   <= w_op;
            r_s1_pix  <= i_pix;
            r_s1_fend <= w_fend;
        end
        if (w_s1_adv && (r_s1_op == OP_HOLD)) begin
            r_top_left <= w_rdata;
            r_held     <= r_s1_pix;
        end
    end

    chr420_ram #(
        .WIDTH (3*PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (w_accept && (w_op == OP_STORE)),
        .i_waddr (r_col),
        .i_wdata (i_pix),
        .i_re    (w_accept),
        .i_raddr (r_col),
        .o_rdata (w_rdata_raw)
    );

    assign w_rdata = w_rdata_raw;

    assign o_push          = w_s1_adv && (r_s1_op == OP_DONE);
    assign o_blk.tl        = r_top_left;
    assign o_blk.tr        = w_rdata;
    assign o_blk.bl        = r_held;
    assign o_blk.br        = r_s1_pix;
    assign o_blk.frame_end = r_s1_fend;

endmodule

### hdl/chr420_fifo.sv
// ----------------------------------------------------------------------------
// chr420_fifo
// Short queue of completed blocks between intake and output.
// ----------------------------------------------------------------------------
module chr420_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  chr420_pkg::t_blk    i_data,
    input  logic                i_pop,
    output chr420_pkg::t_blk    o_data,
    output chr420_pkg::t_q_stat o_stat
);
    import chr420_pkg::*;

    t_blk              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] n_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QPTR_W-1:0] n_rptr;
    logic [QPTR_W:0]   r_count;
    logic [QPTR_W:0]   n_count;
    logic              w_push;
    logic              w_pop;

    assign w_push = i_push && !o_stat.full;
    assign w_pop  = i_pop && !o_stat.empty;

    always_comb begin
        n_wptr  = w_push ? r_wptr + QPTR_W'(1) : r_wptr;
        n_rptr  = w_pop ? r_rptr + QPTR_W'(1) : r_rptr;
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + (QPTR_W+1)'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_data       = r_mem[r_rptr];
    assign o_stat.full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_stat.count = r_count;

endmodule

### hdl/chr420_back.sv
// ----------------------------------------------------------------------------
// chr420_back
// Chroma averaging and output register of the 4:2:0 samples.
// ----------------------------------------------------------------------------
module chr420_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    input  chr420_pkg::t_blk             i_blk,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [chr420_pkg::PIX_W-1:0] o_luma_top_left,
    output logic [chr420_pkg::PIX_W-1:0] o_luma_top_right,
    output logic [chr420_pkg::PIX_W-1:0] o_luma_bottom_left,
    output logic [chr420_pkg::PIX_W-1:0] o_luma_bottom_right,
    output logic [chr420_pkg::PIX_W-1:0] o_blue_chroma_mean,
    output logic [chr420_pkg::PIX_W-1:0] o_red_chroma_mean,
    output logic                         o_frame_end
);
    import chr420_pkg::*;

    localparam int SW = PIX_W + 2;

    logic [SW-1:0]    w_cb_sum;
    logic [SW-1:0]    w_cr_sum;
    logic             r_vld;
    logic             n_vld;
    logic [PIX_W-1:0] r_ytl;
    logic [PIX_W-1:0] r_ytr;
    logic [PIX_W-1:0] r_ybl;
    logic [PIX_W-1:0] r_ybr;
    logic [PIX_W-1:0] r_cb;
    logic [PIX_W-1:0] r_cr;
    logic             r_fend;

    assign o_pop = i_q_valid && (!r_vld || i_ready);

    assign w_cb_sum = SW'(i_blk.tl.cb) + SW'(i_blk.tr.cb) + SW'(i_blk.bl.cb) + SW'(i_blk.br.cb);
    assign w_cr_sum = SW'(i_blk.tl.cr) + SW'(i_blk.tr.cr) + SW'(i_blk.bl.cr) + SW'(i_blk.br.cr);

    always_comb begin
        n_vld = r_vld;
        if (o_pop) begin
            n_vld = 1'b1;
        end else if (i_ready) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ytl  <= i_blk.tl.y;
            r_ytr  <= i_blk.tr.y;
            r_ybl  <= i_blk.bl.y;
            r_ybr  <= i_blk.br.y;
            r_cb   <= w_cb_sum[SW-1:2];
            r_cr   <= w_cr_sum[SW-1:2];
            r_fend <= i_blk.frame_end;
        end
    end

    assign o_valid             = r_vld;
    assign o_luma_top_left     = r_ytl;
    assign o_luma_top_right    = r_ytr;
    assign o_luma_bottom_left  = r_ybl;
    assign o_luma_bottom_right = r_ybr;
    assign o_blue_chroma_mean  = r_cb;
    assign o_red_chroma_mean   = r_cr;
    assign o_frame_end         = r_fend;

endmodule

### hdl/chroma_420_downsampler.sv
// ----------------------------------------------------------------------------
// chroma_420_downsampler
// 4:2:0 chroma subsampling of a raster-order YCbCr pixel stream.
//
// Input channel: one pixel (Y, Cb, Cr) per transfer, raster order.
// Output channel: one sample per 2x2 block: four luma values, the truncated
// mean of the four Cb and of the four Cr values, and a frame end flag on the
// last block of the frame. Odd trailing columns and rows are consumed and
// produce nothing.
// Throughput: one pixel per cycle, but input stalls while a block-completing
// pixel waits in the intake stage for room in the full block queue. A
// completed block goes through the queue to the output register. Frame size
// comes from two APB registers (width at 0x0, height at 0x4); the user must
// write them only while the block is idle; the block does not enforce it.
// Reset: counters return to the top left pixel, size returns to 640x480;
// the line store is not cleared and needs no clearing pass.
// A stalled receiver fills the output register and a two-entry block queue;
// after that, input transfers stop at the next block-completing pixel.
// ----------------------------------------------------------------------------
`include "chroma_420_downsampler_macros.svh"

module chroma_420_downsampler #(
    parameter int MAX_WIDTH = chr420_pkg::MAX_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [chr420_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [chr420_pkg::APB_DATA_W-1:0] pwdata,
    output logic [chr420_pkg::APB_DATA_W-1:0] prdata,
    output logic                              pready,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [chr420_pkg::PIX_W-1:0]      i_luma,
    input  logic [chr420_pkg::PIX_W-1:0]      i_blue_chroma,
    input  logic [chr420_pkg::PIX_W-1:0]      i_red_chroma,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [chr420_pkg::PIX_W-1:0]      o_luma_top_left,
    output logic [chr420_pkg::PIX_W-1:0]      o_luma_top_right,
    output logic [chr420_pkg::PIX_W-1:0]      o_luma_bottom_left,
    output logic [chr420_pkg::PIX_W-1:0]      o_luma_bottom_right,
    output logic [chr420_pkg::PIX_W-1:0]      o_blue_chroma_mean,
    output logic [chr420_pkg::PIX_W-1:0]      o_red_chroma_mean,
    output logic                              o_frame_end
);
    import chr420_pkg::*;

    logic [CFG_W-1:0] r_frame_width;
    logic [CFG_W-1:0] r_frame_height;
    logic             w_cfg_wr;
    logic             w_sel_reg;
    t_pix             w_pix;
    logic             w_push;
    t_blk             w_push_blk;
    t_blk             w_q_blk;
    t_q_stat          w_q_stat;
    logic             w_pop;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_sel_reg = paddr[APB_ADDR_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= CFG_W'(DEF_WIDTH);
            r_frame_height <= CFG_W'(DEF_HEIGHT);
        end else if (w_cfg_wr) begin
            case (w_sel_reg)
                REG_FRAME_WIDTH: begin
                    r_frame_width <= pwdata[CFG_W-1:0];
                end
                REG_FRAME_HEIGHT: begin
                    r_frame_height <= pwdata[CFG_W-1:0];
                end
                default: begin
                    r_frame_width <= r_frame_width;
                end
            endcase
        end
    end

    always_comb begin
        case (w_sel_reg)
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(r_frame_height);
            default:          prdata = '0;
        endcase
    end

    assign w_pix.y  = i_luma;
    assign w_pix.cb = i_blue_chroma;
    assign w_pix.cr = i_red_chroma;

    chr420_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_valid        (i_in_valid),
        .o_ready        (o_in_ready),
        .i_pix          (w_pix),
        .o_push         (w_push),
        .o_blk          (w_push_blk),
        .i_q_full       (w_q_stat.full)
    );

    chr420_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_blk),
        .i_pop   (w_pop),
        .o_data  (w_q_blk),
        .o_stat  (w_q_stat)
    );

    chr420_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_q_valid           (!w_q_stat.empty),
        .i_blk               (w_q_blk),
        .o_pop               (w_pop),
        .o_valid             (o_out_valid),
        .i_ready             (i_out_ready),
        .o_luma_top_left     (o_luma_top_left),
        .o_luma_top_right    (o_luma_top_right),
        .o_luma_bottom_left  (o_luma_bottom_left),
        .o_luma_bottom_right (o_luma_bottom_right),
        .o_blue_chroma_mean  (o_blue_chroma_mean),
        .o_red_chroma_mean   (o_red_chroma_mean),
        .o_frame_end         (o_frame_end)
    );

    `CHR_ASSERT_IMP(a_stall_only_on_full, i_clk, i_rst_n, !o_in_ready, w_q_stat.full)
    `CHR_ASSERT_IMP(a_queue_bound, i_clk, i_rst_n, 1'b1, w_q_stat.count <= (QPTR_W+1)'(QUEUE_DEPTH))
    `CHR_ASSERT_IMP(a_pop_into_free_slot, i_clk, i_rst_n, w_pop, !o_out_valid || i_out_ready)
    `CHR_ASSERT_NXT(a_pop_shows_sample, i_clk, i_rst_n, w_pop, o_out_valid)

endmodule
